@@ rtl/rmeu_pkg.sv @@
// ----------------------------------------------------------------------------
// rmeu_pkg
// Shared codes and controller/datapath interface types for the
// reachability matrix edge update block.
// ----------------------------------------------------------------------------
package rmeu_pkg;

	localparam int FUNC_W      = 2;
	localparam int IDX_W       = 5;
	localparam int WORD_W      = 32;
	localparam int NODES_W     = 6;

	localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_EDGE  = 2'd2;

	localparam logic [NODES_W-1:0] NODES_RESET = 6'd32;

	// controller -> datapath
	typedef struct packed {
		logic capture;    // latch the input item
		logic wr_target;  // store the captured row, result = stored row
		logic rd_target;  // read the target row
		logic rd_i;       // read row i
		logic rd_j;       // read row j
		logic ld_i;       // load row i register from read data
		logic ld_j;       // load row j register, set mark [j][i], start walk
		logic walk;       // one walk step on row k
		logic wb_i;       // write row i register back
		logic wb_j;       // write row j register back, result = row j, column
		logic res_read;   // result = read data
		logic res_zero;   // result = zero
		logic out_load;   // move result into the output register
	} rmeu_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              target_ok;
		logic              edge_ok;
		logic              walk_last;
		logic              out_free;
	} rmeu_stat_t;

endpackage

@@ rtl/rmeu_datapath.sv @@
// ----------------------------------------------------------------------------
// rmeu_datapath
// Row store, row i / row j working registers, column collector, walk
// counter, result and output registers.
// ----------------------------------------------------------------------------
module rmeu_datapath #(
	parameter int MAX_NODES = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rmeu_pkg::rmeu_cmd_t             cmd,
	output rmeu_pkg::rmeu_stat_t            stat,
	input  logic [rmeu_pkg::FUNC_W-1:0]     func,
	input  logic [rmeu_pkg::IDX_W-1:0]      target_row,
	input  logic [rmeu_pkg::WORD_W-1:0]     row_data_in,
	input  logic [rmeu_pkg::IDX_W-1:0]      first_node,
	input  logic [rmeu_pkg::IDX_W-1:0]      second_node,
	input  logic                            cfg_wr_en,
	input  logic [rmeu_pkg::NODES_W-1:0]    cfg_wr_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [rmeu_pkg::WORD_W-1:0]     row_out,
	output logic [rmeu_pkg::WORD_W-1:0]     column_out
);
	import rmeu_pkg::*;

	localparam int MW = MAX_NODES;
	localparam int AW = $clog2(MAX_NODES);

	// row store with per-row valid bits (unwritten row reads as zero)
	logic [MW-1:0]        mem_q [MAX_NODES];
	logic [MAX_NODES-1:0] vld_q;
	logic [MW-1:0]        rd_data_q;
	logic                 rd_vld_q;
	logic [AW-1:0]        rd_addr;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic [MW-1:0]        wr_data;

	// captured item
	logic [FUNC_W-1:0]    func_q;
	logic [AW-1:0]        target_q;
	logic [MW-1:0]        data_q;
	logic [AW-1:0]        i_q;
	logic [AW-1:0]        j_q;
	logic                 target_ok_q;
	logic                 edge_ok_q;
	logic                 same_q;

	logic [NODES_W-1:0]   nodes_q;
	logic [AW-1:0]        k_q;
	logic [AW-1:0]        k_next;
	logic [MW-1:0]        ri_q;
	logic [MW-1:0]        rj_q;
	logic [WORD_W-1:0]    col_q;
	logic [WORD_W-1:0]    res_row_q;
	logic [WORD_W-1:0]    res_col_q;
	logic                 out_valid_q;
	logic [WORD_W-1:0]    row_out_q;
	logic [WORD_W-1:0]    col_out_q;

	// walk step
	logic [MW-1:0]        rd_row;
	logic                 upd;
	logic [MW-1:0]        rj_a;
	logic [MW-1:0]        ri_a;
	logic [MW-1:0]        rowk;
	logic [MW-1:0]        rowk_upd;
	logic [MW-1:0]        mark_i;

	assign rd_row = rd_vld_q ? rd_data_q : '0;
	assign mark_i = MW'(1) << i_q;
	assign upd    = int'(k_q) < int'(nodes_q);
	assign k_next = (int'(k_q) == MAX_NODES - 1) ? '0 : k_q + AW'(1);

	always_comb begin
		rj_a = (upd && ri_q[k_q]) ? (rj_q | (MW'(1) << k_q)) : rj_q;
		ri_a = same_q ? rj_a : ri_q;
		if (k_q == j_q) begin
			rowk = rj_a;
		end else if (k_q == i_q) begin
			rowk = ri_a;
		end else begin
			rowk = rd_row;
		end
		rowk_upd = (upd && rowk[j_q]) ? (rowk | mark_i) : rowk;
	end

	always_comb begin
		if (cmd.rd_target) begin
			rd_addr = target_q;
		end else if (cmd.rd_i) begin
			rd_addr = i_q;
		end else if (cmd.rd_j) begin
			rd_addr = j_q;
		end else if (cmd.walk) begin
			rd_addr = k_next;
		end else begin
			rd_addr = '0;  // walk start
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = k_q;
		wr_data = rowk_upd;
		if (cmd.wr_target) begin
			wr_en   = 1'b1;
			wr_addr = target_q;
			wr_data = data_q;
		end else if (cmd.wb_i) begin
			wr_en   = 1'b1;
			wr_addr = i_q;
			wr_data = ri_q;
		end else if (cmd.wb_j) begin
			wr_en   = 1'b1;
			wr_addr = j_q;
			wr_data = rj_q;
		end else if (cmd.walk) begin
			wr_en   = upd && (k_q != i_q) && (k_q != j_q);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
		rd_vld_q  <= vld_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_q <= NODES_RESET;
		end else if (cfg_wr_en) begin
			nodes_q <= cfg_wr_data;
		end
	end

	// captured item and working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q      <= func;
			target_q    <= AW'(target_row);
			data_q      <= MW'(row_data_in);
			i_q         <= AW'(first_node);
			j_q         <= AW'(second_node);
			target_ok_q <= int'(target_row) < MAX_NODES;
			edge_ok_q   <= (int'(first_node) < MAX_NODES) && (int'(second_node) < MAX_NODES);
			same_q      <= first_node == second_node;
		end
		if (cmd.ld_i) begin
			ri_q <= rd_row;
		end
		if (cmd.ld_j) begin
			rj_q  <= rd_row | mark_i;
			k_q   <= '0;
			col_q <= '0;
			if (same_q) begin
				ri_q <= rd_row | mark_i;
			end
		end
		if (cmd.walk) begin
			ri_q <= (k_q == i_q) ? rowk_upd : ri_a;
			rj_q <= (k_q == j_q) ? rowk_upd : rj_a;
			k_q  <= k_next;
			if (int'(k_q) < WORD_W) begin
				col_q[IDX_W'(k_q)] <= rowk_upd[i_q];
			end
		end
		if (cmd.wr_target) begin
			res_row_q <= WORD_W'(data_q);
			res_col_q <= '0;
		end else if (cmd.res_read) begin
			res_row_q <= WORD_W'(rd_row);
			res_col_q <= '0;
		end else if (cmd.wb_j) begin
			res_row_q <= WORD_W'(rj_q);
			res_col_q <= col_q;
		end else if (cmd.res_zero) begin
			res_row_q <= '0;
			res_col_q <= '0;
		end
		if (cmd.out_load) begin
			row_out_q <= res_row_q;
			col_out_q <= res_col_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign row_out    = row_out_q;
	assign column_out = col_out_q;

	assign stat.func      = func_q;
	assign stat.target_ok = target_ok_q;
	assign stat.edge_ok   = edge_ok_q;
	assign stat.walk_last = int'(k_q) == MAX_NODES - 1;
	assign stat.out_free  = !out_valid_q || !out_stall;

endmodule

@@ rtl/rmeu_ctrl.sv @@
// ----------------------------------------------------------------------------
// rmeu_ctrl
// Sequencer: decodes the captured operation and steps the datapath
// through read, walk, write-back and result hand-off.
// ----------------------------------------------------------------------------
module rmeu_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  rmeu_pkg::rmeu_stat_t stat,
	output rmeu_pkg::rmeu_cmd_t  cmd
);
	import rmeu_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DISPATCH = 4'd1;
	localparam logic [3:0] S_RD_WAIT  = 4'd2;
	localparam logic [3:0] S_EDGE_RJ  = 4'd3;
	localparam logic [3:0] S_EDGE_LD  = 4'd4;
	localparam logic [3:0] S_WALK     = 4'd5;
	localparam logic [3:0] S_WB_I     = 4'd6;
	localparam logic [3:0] S_WB_J     = 4'd7;
	localparam logic [3:0] S_DONE     = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	assign in_stall = state_q != S_IDLE;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_nxt = S_DONE;
				unique case (stat.func)
					FUNC_WRITE: begin
						cmd.wr_target = stat.target_ok;
						cmd.res_zero  = !stat.target_ok;
					end
					FUNC_READ: begin
						if (stat.target_ok) begin
							cmd.rd_target = 1'b1;
							state_nxt     = S_RD_WAIT;
						end else begin
							cmd.res_zero = 1'b1;
						end
					end
					FUNC_EDGE: begin
						if (stat.edge_ok) begin
							cmd.rd_i  = 1'b1;
							state_nxt = S_EDGE_RJ;
						end else begin
							cmd.res_zero = 1'b1;
						end
					end
					default: begin
						cmd.res_zero = 1'b1;
					end
				endcase
			end
			S_RD_WAIT: begin
				cmd.res_read = 1'b1;
				state_nxt    = S_DONE;
			end
			S_EDGE_RJ: begin
				cmd.rd_j  = 1'b1;
				cmd.ld_i  = 1'b1;
				state_nxt = S_EDGE_LD;
			end
			S_EDGE_LD: begin
				cmd.ld_j  = 1'b1;
				state_nxt = S_WALK;
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (stat.walk_last) begin
					state_nxt = S_WB_I;
				end
			end
			S_WB_I: begin
				cmd.wb_i  = 1'b1;
				state_nxt = S_WB_J;
			end
			S_WB_J: begin
				cmd.wb_j  = 1'b1;
				state_nxt = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

@@ rtl/reachability_matrix_edge_update.sv @@
// ----------------------------------------------------------------------------
// reachability_matrix_edge_update
// N-by-N path mark matrix with row write, row read and edge insertion
// that propagates row i into row j and column j into column i.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+---------------------------------------------
//  in       | in_valid / in_stall   | func, target_row, row_data_in, first_node,
//           |                       | second_node
//  out      | out_valid / out_stall | row_out, column_out
//  cfg      | cfg_wr_en             | cfg_wr_data (nodes_in_use)
//
//  A write, an unused code or an out-of-range index goes from dispatch straight
//  to the result; a read waits for the row store read data; an edge insertion
//  walks over every row of the row store, with rows i and j held in registers.
//  One item is in work at a time; a new item is taken once the previous
//  result sits in the output register, even while that result is stalled.
//  Reset: all rows read as zero (per-row valid bits), nodes_in_use = 32.
//  An output stall only holds the sequencer in its hand-off state.
//
module reachability_matrix_edge_update #(
	parameter int MAX_NODES = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [rmeu_pkg::FUNC_W-1:0]     func,
	input  logic [rmeu_pkg::IDX_W-1:0]      target_row,
	input  logic [rmeu_pkg::WORD_W-1:0]     row_data_in,
	input  logic [rmeu_pkg::IDX_W-1:0]      first_node,
	input  logic [rmeu_pkg::IDX_W-1:0]      second_node,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [rmeu_pkg::WORD_W-1:0]     row_out,
	output logic [rmeu_pkg::WORD_W-1:0]     column_out,
	input  logic                            cfg_wr_en,
	input  logic [rmeu_pkg::NODES_W-1:0]    cfg_wr_data
);
	import rmeu_pkg::*;

	rmeu_cmd_t  cmd;
	rmeu_stat_t stat;

	// sequencer: one state per phase of an operation
	rmeu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// row store, row i/j registers, walk counter, column collector, output reg.
	// Walk step k: row j picks up bit k if row i has it, then row k picks up
	// bit i if it has bit j; rows i and j live in registers during the walk.
	rmeu_datapath #(
		.MAX_NODES (MAX_NODES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.func        (func),
		.target_row  (target_row),
		.row_data_in (row_data_in),
		.first_node  (first_node),
		.second_node (second_node),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.row_out     (row_out),
		.column_out  (column_out)
	);

endmodule

@@ rtl/rmeu_checker.sv @@
// ----------------------------------------------------------------------------
// rmeu_checker
// Port-level checks for the reachability matrix edge update block.
// ----------------------------------------------------------------------------
module rmeu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] row_out,
	input logic [31:0] column_out
);

	// a held result stays valid
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// one item at a time: a transfer in closes the input side next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken before first finished");

	// no result can appear right after an item is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result appeared without processing");

	// a held result does not change
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(row_out) && $stable(column_out))
		else $error("result changed while stalled");

endmodule

bind reachability_matrix_edge_update rmeu_checker u_rmeu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.row_out    (row_out),
	.column_out (column_out)
);
